[sv/assert_macros.svh]
// Assertion macros shared by the RTL of the index transform block.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define APIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define APIT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/apit_pkg.sv]
// Package of the index transform block: widths, mode and register codes, stage record.
// No dependencies; used by apit_div and array_partition_index_transform_top.
package apit_pkg;

  localparam int IDX_W = 24;
  localparam int DIV_W = IDX_W + 1;
  localparam int ADR_W = IDX_W + 2;
  localparam int CFG_W = 3;
  localparam int MODE_W = 3;

  // Edges from the accepting edge to the edge that takes the result.
  localparam int PIPE_LAT = 2 * DIV_W + 11;

  localparam logic [MODE_W-1:0] MODE_VOID    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BSIZE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BCOUNT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STRIDE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BSTRIDE = 3'd4;

  localparam logic [CFG_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_W-1:0] CFG_BSIZE  = 3'd1;
  localparam logic [CFG_W-1:0] CFG_PLIMIT = 3'd2;
  localparam logic [CFG_W-1:0] CFG_FPAD   = 3'd3;
  localparam logic [CFG_W-1:0] CFG_RPAD   = 3'd4;
  localparam logic [CFG_W-1:0] CFG_EXCL   = 3'd5;

  // Working record of one request as it moves down the pipeline.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] z;
    logic [DIV_W-1:0] len;
    logic [DIV_W-1:0] cnt;
    logic [DIV_W-1:0] cntm1;
    logic [DIV_W-1:0] dva;
    logic [DIV_W-1:0] qz;
    logic [DIV_W-1:0] rz;
    logic [DIV_W-1:0] ql;
    logic [DIV_W-1:0] rl;
    logic [DIV_W-1:0] c4;
    logic [DIV_W-1:0] chunk;
    logic [DIV_W-1:0] q2;
    logic [DIV_W-1:0] r2;
    logic [DIV_W-1:0] q3;
    logic [DIV_W-1:0] r3;
    logic [DIV_W-1:0] part;
    logic [DIV_W-1:0] npart;
    logic [DIV_W-1:0] ent3;
    logic [DIV_W-1:0] ent4;
    logic [IDX_W-1:0] mloc;
    logic [IDX_W-1:0] ment;
    logic [IDX_W-1:0] loc4;
    logic [IDX_W-1:0] phi_str;
    logic [ADR_W-1:0] tb;
    logic [ADR_W-1:0] beg;
    logic [ADR_W-1:0] e_raw;
    logic [ADR_W-1:0] bend;
    logic [ADR_W-1:0] nb;
    logic [ADR_W-1:0] pb;
    logic [ADR_W-1:0] pe;
    logic [ADR_W-1:0] ne_raw;
    logic [ADR_W-1:0] ne;
    logic [ADR_W-1:0] plo_pad;
    logic [ADR_W-1:0] phi_pad;
    logic             has_prev;
    logic             has_next;
    logic             is_last;
    logic             p2last;
    logic             front;
    logic             rear;
    logic             nv;
  } item_t;

endpackage

[sv/apit_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on apit_pkg for the operand width.
module apit_div (
  input  logic                       clk,
  input  logic [apit_pkg::DIV_W-1:0] dividend,
  input  logic [apit_pkg::DIV_W-1:0] divisor,
  output logic [apit_pkg::DIV_W-1:0] quotient,
  output logic [apit_pkg::DIV_W-1:0] remainder
);
  import apit_pkg::*;

  logic [DIV_W-1:0] rem_r [DIV_W];
  logic [DIV_W-1:0] quo_r [DIV_W];
  logic [DIV_W-1:0] dvd_r [DIV_W];
  logic [DIV_W-1:0] dsr_r [DIV_W];
  logic [DIV_W-1:0] rem_nxt [DIV_W];
  logic [DIV_W-1:0] quo_nxt [DIV_W];
  logic [DIV_W-1:0] dvd_nxt [DIV_W];
  logic [DIV_W-1:0] dsr_nxt [DIV_W];

  // Each stage shifts in the next dividend bit and subtracts the divisor if it fits.
  always_comb begin
    logic [DIV_W-1:0] pr;
    logic [DIV_W-1:0] pd;
    logic [DIV_W-1:0] pq;
    logic [DIV_W-1:0] ps;
    logic [DIV_W:0]   sh;
    logic [DIV_W:0]   df;
    for (int k = 0; k < DIV_W; k++) begin
      if (k == 0) begin
        pr = '0;
        pd = dividend;
        pq = '0;
        ps = divisor;
      end else begin
        pr = rem_r[k-1];
        pd = dvd_r[k-1];
        pq = quo_r[k-1];
        ps = dsr_r[k-1];
      end
      sh = {pr, pd[DIV_W-1]};
      df = sh - {1'b0, ps};
      if (sh >= {1'b0, ps}) begin
        rem_nxt[k] = df[DIV_W-1:0];
        quo_nxt[k] = {pq[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = sh[DIV_W-1:0];
        quo_nxt[k] = {pq[DIV_W-2:0], 1'b0};
      end
      dvd_nxt[k] = {pd[DIV_W-2:0], 1'b0};
      dsr_nxt[k] = ps;
    end
  end

  // Stage registers carry data only; validity travels beside them.
  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_W; k++) begin
      rem_r[k] <= rem_nxt[k];
      quo_r[k] <= quo_nxt[k];
      dvd_r[k] <= dvd_nxt[k];
      dsr_r[k] <= dsr_nxt[k];
    end
  end

  assign quotient  = quo_r[DIV_W-1];
  assign remainder = rem_r[DIV_W-1];

endmodule

[sv/array_partition_index_transform_top.sv]
// Top level of the block-cyclic index transform: configuration registers and pipeline.
// Depends on apit_pkg, apit_div and assert_macros.svh.
//
// The block takes one request in every clock cycle and never raises busy. Each result
// is shown for one cycle under out_strobe, and results leave in request order. The
// pipeline has two 25-stage dividers in series, one quotient bit per stage, with
// four stages in front, one between them and six behind. The receiver cannot stall the
// block, so a result must be taken in the cycle it is shown. The user must write
// registers only while no request is in flight; the block does not enforce this.
`include "assert_macros.svh"

module array_partition_index_transform_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [apit_pkg::IDX_W-1:0] in_global_index,
  input  logic [apit_pkg::IDX_W-1:0] in_parent_low,
  input  logic [apit_pkg::IDX_W-1:0] in_parent_high,
  output logic                       out_strobe,
  output logic [apit_pkg::IDX_W-1:0] out_part_number,
  output logic [apit_pkg::IDX_W-1:0] out_local_index,
  output logic [apit_pkg::IDX_W-1:0] out_part_low,
  output logic [apit_pkg::IDX_W-1:0] out_part_high,
  output logic                       out_neighbour_valid,
  output logic [apit_pkg::IDX_W-1:0] out_neighbour_part,
  output logic [apit_pkg::IDX_W-1:0] out_neighbour_low,
  output logic [apit_pkg::IDX_W-1:0] out_neighbour_high,
  input  logic                       cfg_we,
  input  logic [apit_pkg::CFG_W-1:0] cfg_index,
  input  logic [apit_pkg::IDX_W-1:0] cfg_data
);
  import apit_pkg::*;

  // Configuration registers.
  logic [MODE_W-1:0] mode_r;
  logic [IDX_W-1:0]  bsize_r;
  logic [IDX_W-1:0]  plimit_r;
  logic [IDX_W-1:0]  fpad_r;
  logic [IDX_W-1:0]  rpad_r;
  logic              excl_r;

  // Derived configuration.
  logic [IDX_W-1:0] bs_eff;
  logic [IDX_W-1:0] lim_eff;
  logic [DIV_W-1:0] bs_d;
  logic [DIV_W-1:0] lim_d;
  logic [ADR_W-1:0] fp_a;
  logic [ADR_W-1:0] rp_a;
  logic             padded;
  logic             accept;

  // Stage registers and valid bits.
  item_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r, s8_r, s9_r, s10_r;
  item_t s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt, s6_nxt, s7_nxt, s8_nxt, s9_nxt, s10_nxt;
  item_t pa_r [DIV_W];
  item_t pb_r [DIV_W];
  logic  v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r;
  logic [DIV_W-1:0] va_r;
  logic [DIV_W-1:0] vb_r;

  // Divider ports.
  logic [DIV_W-1:0] qa0, ra0, qa1, ra1, qb0, rb0, qb1, rb1;
  logic [DIV_W-1:0] db0_dvd, db0_dsr;

  // Multiplier products.
  logic [2*IDX_W-1:0] prod_loc;
  logic [2*IDX_W-1:0] prod_ent;

  // Output registers.
  logic             out_strobe_r;
  logic [IDX_W-1:0] out_part_number_r, out_local_index_r, out_part_low_r, out_part_high_r;
  logic             out_neighbour_valid_r;
  logic [IDX_W-1:0] out_neighbour_part_r, out_neighbour_low_r, out_neighbour_high_r;
  logic [IDX_W-1:0] out_part_number_nxt, out_local_index_nxt, out_part_low_nxt;
  logic [IDX_W-1:0] out_part_high_nxt;
  logic             out_neighbour_valid_nxt;
  logic [IDX_W-1:0] out_neighbour_part_nxt, out_neighbour_low_nxt, out_neighbour_high_nxt;
  logic [ADR_W-1:0] nlo_pad, nhi_pad, nhi_sum;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Register writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_VOID;
      bsize_r  <= IDX_W'(1);
      plimit_r <= IDX_W'(1);
      fpad_r   <= '0;
      rpad_r   <= '0;
      excl_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_data[MODE_W-1:0];
        CFG_BSIZE:  bsize_r  <= cfg_data;
        CFG_PLIMIT: plimit_r <= cfg_data;
        CFG_FPAD:   fpad_r   <= cfg_data;
        CFG_RPAD:   rpad_r   <= cfg_data;
        CFG_EXCL:   excl_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A zero block size or part limit behaves as one.
  assign bs_eff  = bsize_r | IDX_W'(bsize_r == '0);
  assign lim_eff = plimit_r | IDX_W'(plimit_r == '0);
  assign bs_d    = DIV_W'(bs_eff);
  assign lim_d   = DIV_W'(lim_eff);
  assign fp_a    = ADR_W'(fpad_r);
  assign rp_a    = ADR_W'(rpad_r);
  assign padded  = ((fpad_r | rpad_r) != '0) && !excl_r;

  // Stage 1: capture the request.
  always_comb begin
    s1_nxt     = '0;
    s1_nxt.idx = in_global_index;
    s1_nxt.lo  = in_parent_low;
    s1_nxt.hi  = in_parent_high;
  end

  // Stage 2: repair an inverted range and clamp the index into it.
  always_comb begin
    s2_nxt = s1_r;
    if (s1_r.hi < s1_r.lo) begin
      s2_nxt.hi = s1_r.lo;
    end
    if (s1_r.idx < s1_r.lo) begin
      s2_nxt.idx = s1_r.lo;
    end else if (s1_r.idx > s2_nxt.hi) begin
      s2_nxt.idx = s2_nxt.hi;
    end
  end

  // Stage 3: range length and offset of the index.
  always_comb begin
    s3_nxt     = s2_r;
    s3_nxt.len = DIV_W'(s2_r.hi) - DIV_W'(s2_r.lo) + DIV_W'(1);
    s3_nxt.z   = s2_r.idx - s2_r.lo;
  end

  // Stage 4: part count and the divisor of the first division.
  always_comb begin
    s4_nxt     = s3_r;
    s4_nxt.cnt = (lim_d < s3_r.len) ? lim_d : s3_r.len;
    if (mode_r == MODE_BSIZE || mode_r == MODE_BSTRIDE) begin
      s4_nxt.dva = bs_d;
    end else begin
      s4_nxt.dva = s4_nxt.cnt;
    end
  end

  // First division: offset and length by block size or part count.
  apit_div u_div_a0 (
    .clk       (clk),
    .dividend  (DIV_W'(s4_r.z)),
    .divisor   (s4_r.dva),
    .quotient  (qa0),
    .remainder (ra0)
  );

  apit_div u_div_a1 (
    .clk       (clk),
    .dividend  (s4_r.len),
    .divisor   (s4_r.dva),
    .quotient  (qa1),
    .remainder (ra1)
  );

  // Stage 5: collect the first quotients and set up the second division.
  always_comb begin
    logic [DIV_W-1:0] c4m;
    s5_nxt       = pa_r[DIV_W-1];
    s5_nxt.qz    = qa0;
    s5_nxt.rz    = ra0;
    s5_nxt.ql    = qa1;
    s5_nxt.rl    = ra1;
    c4m          = (qa1 < lim_d) ? qa1 : lim_d;
    s5_nxt.c4    = c4m | DIV_W'(c4m == '0);
    s5_nxt.cntm1 = pa_r[DIV_W-1].cnt - DIV_W'(1);
    s5_nxt.tb    = ADR_W'(pa_r[DIV_W-1].hi) + ADR_W'(1) - ADR_W'(ra1);
    s5_nxt.chunk = (mode_r == MODE_BSIZE) ? bs_d : qa1;
  end

  // Second division: block stride splits the block number by the part count,
  // block count splits the offset by the block length.
  assign db0_dvd = (mode_r == MODE_BSTRIDE) ? s5_r.qz : DIV_W'(s5_r.z);
  assign db0_dsr = (mode_r == MODE_BSTRIDE) ? s5_r.c4 : s5_r.ql;

  apit_div u_div_b0 (
    .clk       (clk),
    .dividend  (db0_dvd),
    .divisor   (db0_dsr),
    .quotient  (qb0),
    .remainder (rb0)
  );

  apit_div u_div_b1 (
    .clk       (clk),
    .dividend  (s5_r.ql),
    .divisor   (s5_r.c4),
    .quotient  (qb1),
    .remainder (rb1)
  );

  // Stage 6: block-stride products, owning part and start of its block.
  assign prod_loc = qb0[IDX_W-1:0] * bs_eff;
  assign prod_ent = qb1[IDX_W-1:0] * bs_eff;

  always_comb begin
    s6_nxt      = pb_r[DIV_W-1];
    s6_nxt.q2   = qb0;
    s6_nxt.r2   = rb0;
    s6_nxt.q3   = qb1;
    s6_nxt.r3   = rb1;
    s6_nxt.mloc = prod_loc[IDX_W-1:0];
    s6_nxt.ment = prod_ent[IDX_W-1:0];
    case (mode_r)
      MODE_BSIZE: begin
        s6_nxt.part = pb_r[DIV_W-1].qz;
        s6_nxt.beg  = ADR_W'(pb_r[DIV_W-1].idx) - ADR_W'(pb_r[DIV_W-1].rz);
      end
      MODE_BCOUNT: begin
        // Indices in the remainder tail belong to the last part.
        if (qb0 >= pb_r[DIV_W-1].cnt) begin
          s6_nxt.part = pb_r[DIV_W-1].cntm1;
          s6_nxt.beg  = pb_r[DIV_W-1].tb - ADR_W'(pb_r[DIV_W-1].ql);
        end else begin
          s6_nxt.part = qb0;
          s6_nxt.beg  = ADR_W'(pb_r[DIV_W-1].idx) - ADR_W'(rb0);
        end
      end
      default: ;
    endcase
  end

  // Stage 7: block edges and neighbour starts; stride entry counts.
  always_comb begin
    s7_nxt          = s6_r;
    s7_nxt.e_raw    = s6_r.beg + ADR_W'(s6_r.chunk) - ADR_W'(1);
    s7_nxt.nb       = s6_r.beg + ADR_W'(s6_r.chunk);
    s7_nxt.pb       = s6_r.beg - ADR_W'(s6_r.chunk);
    s7_nxt.pe       = s6_r.beg - ADR_W'(1);
    s7_nxt.is_last  = (s6_r.part == s6_r.cntm1);
    s7_nxt.p2last   = s7_nxt.is_last || (s6_r.part + DIV_W'(1) == s6_r.cntm1);
    s7_nxt.has_prev = (s6_r.part != '0);
    s7_nxt.loc4     = s6_r.mloc + s6_r.rz[IDX_W-1:0];
    if (s6_r.r3 > s6_r.r2) begin
      s7_nxt.ent4 = DIV_W'(s6_r.ment) + bs_d;
    end else if (s6_r.r3 == s6_r.r2) begin
      s7_nxt.ent4 = DIV_W'(s6_r.ment) + s6_r.rl;
    end else begin
      s7_nxt.ent4 = DIV_W'(s6_r.ment);
    end
    s7_nxt.ent3 = s6_r.ql + DIV_W'(s6_r.rl > s6_r.rz);
  end

  // Stage 8: end of the own block and whether a next part exists.
  always_comb begin
    s8_nxt = s7_r;
    if (mode_r == MODE_BSIZE) begin
      s8_nxt.bend     = (s7_r.e_raw < ADR_W'(s7_r.hi)) ? s7_r.e_raw : ADR_W'(s7_r.hi);
      s8_nxt.has_next = (s7_r.nb <= ADR_W'(s7_r.hi));
    end else begin
      s8_nxt.bend     = s7_r.is_last ? ADR_W'(s7_r.hi) : s7_r.e_raw;
      s8_nxt.has_next = !s7_r.is_last;
    end
    s8_nxt.ne_raw = s7_r.nb + ADR_W'(s7_r.chunk) - ADR_W'(1);
    if (mode_r == MODE_BSTRIDE) begin
      s8_nxt.phi_str = s7_r.ent4[IDX_W-1:0] - IDX_W'(1);
    end else begin
      s8_nxt.phi_str = s7_r.ent3[IDX_W-1:0] - IDX_W'(1);
    end
  end

  // Stage 9: end of the next block and the padding zone tests.
  always_comb begin
    s9_nxt = s8_r;
    if (mode_r == MODE_BSIZE) begin
      s9_nxt.ne = (s8_r.ne_raw < ADR_W'(s8_r.hi)) ? s8_r.ne_raw : ADR_W'(s8_r.hi);
    end else begin
      s9_nxt.ne = s8_r.p2last ? ADR_W'(s8_r.hi) : s8_r.ne_raw;
    end
    s9_nxt.front = s8_r.has_prev && ((ADR_W'(s8_r.idx) - s8_r.beg) <= fp_a);
    s9_nxt.rear  = s8_r.has_next && ((s8_r.bend - ADR_W'(s8_r.idx)) <= rp_a);
  end

  // Stage 10: pick the neighbour and pad the own range.
  always_comb begin
    s10_nxt    = s9_r;
    s10_nxt.nv = padded && (s9_r.front || s9_r.rear);
    if (s9_r.front) begin
      s10_nxt.npart = s9_r.part - DIV_W'(1);
      s10_nxt.nb    = s9_r.pb;
      s10_nxt.ne    = s9_r.pe;
    end else begin
      s10_nxt.npart = s9_r.part + DIV_W'(1);
    end
    if ((s9_r.beg - ADR_W'(s9_r.lo)) >= fp_a) begin
      s10_nxt.plo_pad = s9_r.beg - fp_a;
    end else begin
      s10_nxt.plo_pad = ADR_W'(s9_r.lo);
    end
    if ((s9_r.bend + rp_a) < ADR_W'(s9_r.hi)) begin
      s10_nxt.phi_pad = s9_r.bend + rp_a;
    end else begin
      s10_nxt.phi_pad = ADR_W'(s9_r.hi);
    end
  end

  // Output stage: pad the neighbour range and select the result by mode.
  assign nhi_sum = s10_r.ne + rp_a;
  assign nlo_pad = ((s10_r.nb - ADR_W'(s10_r.lo)) >= fp_a) ? (s10_r.nb - fp_a)
                                                            : ADR_W'(s10_r.lo);
  assign nhi_pad = (nhi_sum < ADR_W'(s10_r.hi)) ? nhi_sum : ADR_W'(s10_r.hi);

  always_comb begin
    out_part_number_nxt     = '0;
    out_local_index_nxt     = s10_r.idx;
    out_part_low_nxt        = s10_r.lo;
    out_part_high_nxt       = s10_r.hi;
    out_neighbour_valid_nxt = 1'b0;
    out_neighbour_part_nxt  = '0;
    out_neighbour_low_nxt   = '0;
    out_neighbour_high_nxt  = '0;
    case (mode_r)
      MODE_BSIZE, MODE_BCOUNT: begin
        out_part_number_nxt = s10_r.part[IDX_W-1:0];
        if (padded) begin
          out_part_low_nxt  = s10_r.plo_pad[IDX_W-1:0];
          out_part_high_nxt = s10_r.phi_pad[IDX_W-1:0];
        end else begin
          out_part_low_nxt  = s10_r.beg[IDX_W-1:0];
          out_part_high_nxt = s10_r.bend[IDX_W-1:0];
        end
        if (s10_r.nv) begin
          out_neighbour_valid_nxt = 1'b1;
          out_neighbour_part_nxt  = s10_r.npart[IDX_W-1:0];
          out_neighbour_low_nxt   = nlo_pad[IDX_W-1:0];
          out_neighbour_high_nxt  = nhi_pad[IDX_W-1:0];
        end
      end
      MODE_STRIDE: begin
        out_part_number_nxt = s10_r.rz[IDX_W-1:0];
        out_local_index_nxt = s10_r.qz[IDX_W-1:0];
        out_part_low_nxt    = '0;
        out_part_high_nxt   = s10_r.phi_str;
      end
      MODE_BSTRIDE: begin
        out_part_number_nxt = s10_r.r2[IDX_W-1:0];
        out_local_index_nxt = s10_r.loc4;
        out_part_low_nxt    = '0;
        out_part_high_nxt   = s10_r.phi_str;
      end
      default: ;
    endcase
  end

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      va_r         <= '0;
      v5_r         <= 1'b0;
      vb_r         <= '0;
      v6_r         <= 1'b0;
      v7_r         <= 1'b0;
      v8_r         <= 1'b0;
      v9_r         <= 1'b0;
      v10_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      v1_r         <= accept;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      va_r         <= {va_r[DIV_W-2:0], v4_r};
      v5_r         <= va_r[DIV_W-1];
      vb_r         <= {vb_r[DIV_W-2:0], v5_r};
      v6_r         <= vb_r[DIV_W-1];
      v7_r         <= v6_r;
      v8_r         <= v7_r;
      v9_r         <= v8_r;
      v10_r        <= v9_r;
      out_strobe_r <= v10_r;
    end
  end

  // Stage data; the payload beside each divider moves in step with it.
  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    s3_r  <= s3_nxt;
    s4_r  <= s4_nxt;
    s5_r  <= s5_nxt;
    s6_r  <= s6_nxt;
    s7_r  <= s7_nxt;
    s8_r  <= s8_nxt;
    s9_r  <= s9_nxt;
    s10_r <= s10_nxt;
    pa_r[0] <= s4_r;
    pb_r[0] <= s5_r;
    for (int k = 1; k < DIV_W; k++) begin
      pa_r[k] <= pa_r[k-1];
      pb_r[k] <= pb_r[k-1];
    end
    out_part_number_r     <= out_part_number_nxt;
    out_local_index_r     <= out_local_index_nxt;
    out_part_low_r        <= out_part_low_nxt;
    out_part_high_r       <= out_part_high_nxt;
    out_neighbour_valid_r <= out_neighbour_valid_nxt;
    out_neighbour_part_r  <= out_neighbour_part_nxt;
    out_neighbour_low_r   <= out_neighbour_low_nxt;
    out_neighbour_high_r  <= out_neighbour_high_nxt;
  end

  assign out_strobe          = out_strobe_r;
  assign out_part_number     = out_part_number_r;
  assign out_local_index     = out_local_index_r;
  assign out_part_low        = out_part_low_r;
  assign out_part_high       = out_part_high_r;
  assign out_neighbour_valid = out_neighbour_valid_r;
  assign out_neighbour_part  = out_neighbour_part_r;
  assign out_neighbour_low   = out_neighbour_low_r;
  assign out_neighbour_high  = out_neighbour_high_r;

  // Every request yields exactly one result after the fixed latency.
  `APIT_ASSERT(a_req_to_result, accept |-> ##PIPE_LAT out_strobe, "request lost in the pipeline")
  `APIT_ASSERT(a_result_has_req, out_strobe |-> $past(accept, PIPE_LAT), "result without a request")
  `APIT_ASSERT(a_nb_cleared, (out_strobe && !out_neighbour_valid) |-> (out_neighbour_part == '0 && out_neighbour_low == '0 && out_neighbour_high == '0), "neighbour fields set without a neighbour")
  `APIT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_strobe, "result strobe after reset")

endmodule
